// ----- src/qrs_pkg.sv -----
// Shared widths, status codes and word types of the quadratic root solver.
package qrs_pkg;

    localparam int COEF_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int TOL_W         = 16;
    localparam int ADDR_W        = 3;

    typedef enum logic [2:0] {
        ST_LINEAR   = 3'd0,
        ST_NO_REAL  = 3'd1,
        ST_DOUBLE   = 3'd2,
        ST_TWO      = 3'd3,
        ST_ALL_REAL = 3'd4,
        ST_NONE     = 3'd5
    } t_status;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } t_in_word;

    typedef struct packed {
        logic [2:0]               case_status;
        logic [1:0]               root_count;
        logic signed [COEF_W-1:0] root_one;
        logic signed [COEF_W-1:0] root_two;
        logic                     root_saturated;
    } t_out_word;

endpackage

// ----- src/qrs_sqrt_cell.sv -----
// One stage of the digit-by-digit square root chain: two radicand bits, one root bit.
module qrs_sqrt_cell #(
    parameter int RW = 33,
    parameter int DW = 66
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rad,
    input  logic [RW+1:0] i_rem,
    input  logic [RW-1:0] i_root,
    output logic [DW-1:0] o_rad,
    output logic [RW+1:0] o_rem,
    output logic [RW-1:0] o_root
);

    logic [RW+3:0] cur;
    logic [RW+3:0] trial;
    logic          take;
    logic [RW+3:0] diff;

    always_comb begin
        cur   = {i_rem, i_rad[DW-1:DW-2]};
        trial = {2'b00, i_root, 2'b01};
        take  = (cur >= trial);
        diff  = cur - trial;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rad  <= {i_rad[DW-3:0], 2'b00};
            o_rem  <= take ? diff[RW+1:0] : cur[RW+1:0];
            o_root <= {i_root[RW-2:0], take};
        end
    end

endmodule

// ----- src/qrs_div_cell.sv -----
// One stage of the restoring divider chain: one quotient bit per cell.
module qrs_div_cell #(
    parameter int QW   = 50,
    parameter int DENW = 33
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [QW-1:0]   i_num,
    input  logic [DENW-1:0] i_rem,
    input  logic [DENW-1:0] i_den,
    input  logic [QW-1:0]   i_quo,
    output logic [QW-1:0]   o_num,
    output logic [DENW-1:0] o_rem,
    output logic [DENW-1:0] o_den,
    output logic [QW-1:0]   o_quo
);

    logic [DENW:0] cur;
    logic [DENW:0] diff;
    logic          take;

    always_comb begin
        cur  = {i_rem, i_num[QW-1]};
        take = (cur >= {1'b0, i_den});
        diff = cur - {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num <= {i_num[QW-2:0], 1'b0};
            o_rem <= take ? diff[DENW-1:0] : cur[DENW-1:0];
            o_den <= i_den;
            o_quo <= {i_quo[QW-2:0], take};
        end
    end

endmodule

// ----- src/quadratic_root_solver.sv -----
// Word path: split, products, case, discriminant, square root, numerators, two dividers,
// Fin 1, Fin 2, output register (Q16.16 by default). Throughput: one word per cycle unless
// the pipe halts; the square root chain (one root bit per cell) and the two divider chains (one
// quotient bit per cell) are fully pipelined. The pipeline halts as a whole only while the
// output is stalled and a finished word waits behind it; bubbles ahead of it wait as well.
// Reset: synchronous, active low; clears all valid bits and zero_tolerance (0).
module quadratic_root_solver #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input word channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  qrs_pkg::t_in_word        i_in_word,
    // result word channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output qrs_pkg::t_out_word       o_out_word,
    // register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [qrs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int W    = qrs_pkg::COEF_W;
    localparam int TW   = qrs_pkg::TOL_W;
    localparam int PW   = 2 * W;          // product width
    localparam int DW   = 2 * W + 2;      // discriminant magnitude, even
    localparam int DSW  = DW + 1;         // signed discriminant
    localparam int RW   = W + 1;          // root width
    localparam int NW   = W + 2;          // numerator magnitude
    localparam int NSW  = W + 3;          // signed numerator
    localparam int QW   = NW + FRAC_BITS; // dividend / quotient width
    localparam int DENW = W + 1;          // divisor width

    localparam logic [QW-1:0] QLIM = QW'(1) << (W - 1);
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    // K_QUAD is resolved into K_FIXED, K_DOUBLE or K_TWO once the discriminant is known.
    typedef enum logic [2:0] {
        K_FIXED,
        K_LINEAR,
        K_DOUBLE,
        K_TWO,
        K_QUAD
    } t_kind;

    typedef struct packed {
        t_kind           kind;
        qrs_pkg::t_status status;
        logic [1:0]      count;
        logic            an;
        logic            bn;
        logic            cn;
        logic [W-1:0]    am;
        logic [W-1:0]    bm;
        logic [W-1:0]    cm;
        logic            q1n;
        logic            q2n;
    } t_side;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    logic [TW-1:0] r_tol;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (cfg_wr && (paddr[2] == 1'b0)) begin
            r_tol <= pwdata[TW-1:0];
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {{(32-TW){1'b0}}, r_tol} : '0;

    // ------------------------------------------------------------------
    // Flow control: one enable for the whole pipe
    // ------------------------------------------------------------------
    logic en;
    logic v_last;
    logic out_load;

    assign en         = !(o_out_valid && i_out_stall && v_last);
    assign o_in_stall = !en;
    assign out_load   = !o_out_valid || !i_out_stall;

    // ------------------------------------------------------------------
    // Stage 1: sign / magnitude split
    // ------------------------------------------------------------------
    t_side r_s1;
    logic  r_v1;
    t_side n_s1;

    always_comb begin
        n_s1        = '0;
        n_s1.kind   = K_FIXED;
        n_s1.status = qrs_pkg::ST_NONE;
        n_s1.an     = i_in_word.coef_a[W-1];
        n_s1.bn     = i_in_word.coef_b[W-1];
        n_s1.cn     = i_in_word.coef_c[W-1];
        n_s1.am     = n_s1.an ? -i_in_word.coef_a : i_in_word.coef_a;
        n_s1.bm     = n_s1.bn ? -i_in_word.coef_b : i_in_word.coef_b;
        n_s1.cm     = n_s1.cn ? -i_in_word.coef_c : i_in_word.coef_c;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= n_s1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: zero tests, b*b and a*c
    // ------------------------------------------------------------------
    t_side         r_s2;
    logic          r_v2;
    logic          r2_az, r2_bz, r2_cz;
    logic [PW-1:0] r2_bb, r2_ac;
    logic [W-1:0]  tol_w;

    assign tol_w = W'(r_tol);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2  <= r_s1;
            r2_az <= (r_s1.am <= tol_w);
            r2_bz <= (r_s1.bm <= tol_w);
            r2_cz <= (r_s1.cm <= tol_w);
            r2_bb <= PW'(r_s1.bm) * PW'(r_s1.bm);
            r2_ac <= PW'(r_s1.am) * PW'(r_s1.cm);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: case split and exact discriminant b^2 - 4ac
    // ------------------------------------------------------------------
    t_side                 r_s3;
    logic                  r_v3;
    logic signed [DSW-1:0] r3_disc;
    t_side                 n_s3;
    logic signed [DSW-1:0] bb_s, ac4_s;

    always_comb begin
        n_s3  = r_s2;
        bb_s  = $signed({{(DSW-PW){1'b0}}, r2_bb});
        ac4_s = $signed({{(DSW-PW-2){1'b0}}, r2_ac, 2'b00});
        priority if (r2_az && r2_bz) begin
            n_s3.kind   = K_FIXED;
            n_s3.status = r2_cz ? qrs_pkg::ST_ALL_REAL : qrs_pkg::ST_NONE;
            n_s3.count  = 2'd0;
        end else if (r2_bz && r2_cz) begin
            n_s3.kind   = K_FIXED;
            n_s3.status = qrs_pkg::ST_DOUBLE;
            n_s3.count  = 2'd1;
        end else if (r2_az) begin
            n_s3.kind   = K_LINEAR;
            n_s3.status = qrs_pkg::ST_LINEAR;
            n_s3.count  = 2'd1;
        end else begin
            n_s3.kind   = K_QUAD;
            n_s3.status = qrs_pkg::ST_TWO;
            n_s3.count  = 2'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3    <= n_s3;
            // same signs: 4ac counts against b^2
            r3_disc <= (r_s2.an == r_s2.cn) ? (bb_s - ac4_s) : (bb_s + ac4_s);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: discriminant sign and tolerance test
    // ------------------------------------------------------------------
    t_side         r_s4;
    logic          r_v4;
    logic [DW-1:0] r4_rad;
    t_side         n_s4;
    logic          d_neg;
    logic          d_small;

    always_comb begin
        n_s4    = r_s3;
        d_neg   = r3_disc[DSW-1];
        d_small = (r3_disc[DW-1:FRAC_BITS] <= (DW-FRAC_BITS)'(r_tol));
        if (r_s3.kind == K_QUAD) begin
            priority if (d_neg) begin
                n_s4.kind   = K_FIXED;
                n_s4.status = qrs_pkg::ST_NO_REAL;
                n_s4.count  = 2'd0;
            end else if (d_small) begin
                n_s4.kind   = K_DOUBLE;
                n_s4.status = qrs_pkg::ST_DOUBLE;
                n_s4.count  = 2'd1;
            end else begin
                n_s4.kind   = K_TWO;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4   <= n_s4;
            r4_rad <= d_neg ? '0 : r3_disc[DW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Square root chain, RW cells
    // ------------------------------------------------------------------
    logic [DW-1:0] sq_rad  [RW];
    logic [RW+1:0] sq_rem  [RW];
    logic [RW-1:0] sq_root [RW];
    t_side         r_sq_side [RW];
    logic          r_sq_v    [RW];

    genvar gi;
    generate
        for (gi = 0; gi < RW; gi++) begin : g_sqrt
            if (gi == 0) begin : g_head
                qrs_sqrt_cell #(.RW(RW), .DW(DW)) u_cell (
                    .i_clk  (i_clk),
                    .i_en   (en),
                    .i_rad  (r4_rad),
                    .i_rem  ('0),
                    .i_root ('0),
                    .o_rad  (sq_rad[gi]),
                    .o_rem  (sq_rem[gi]),
                    .o_root (sq_root[gi])
                );
            end else begin : g_body
                qrs_sqrt_cell #(.RW(RW), .DW(DW)) u_cell (
                    .i_clk  (i_clk),
                    .i_en   (en),
                    .i_rad  (sq_rad[gi-1]),
                    .i_rem  (sq_rem[gi-1]),
                    .i_root (sq_root[gi-1]),
                    .o_rad  (sq_rad[gi]),
                    .o_rem  (sq_rem[gi]),
                    .o_root (sq_root[gi])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_side[0] <= r_s4;
            for (int k = 1; k < RW; k++) begin
                r_sq_side[k] <= r_sq_side[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: numerators, divisor and quotient signs
    // ------------------------------------------------------------------
    t_side           r_s5;
    logic            r_v5;
    logic [NW-1:0]   r5_num1, r5_num2;
    logic [DENW-1:0] r5_den;
    t_side           n_s5;
    logic [NW-1:0]   n_num1, n_num2;
    logic [DENW-1:0] n_den;
    t_side           sq_out;
    logic signed [NSW-1:0] nbv, sxv, sum1, sum2, bmx;

    always_comb begin
        sq_out = r_sq_side[RW-1];
        n_s5   = sq_out;
        bmx    = $signed({3'b000, sq_out.bm});
        nbv    = sq_out.bn ? bmx : -bmx;
        sxv    = $signed({2'b00, sq_root[RW-1]});
        sum1   = nbv + sxv;
        sum2   = nbv - sxv;
        n_num1 = '0;
        n_num2 = '0;
        n_den  = {sq_out.am, 1'b0};
        n_s5.q1n = 1'b0;
        n_s5.q2n = 1'b0;
        unique case (sq_out.kind)
            K_LINEAR: begin
                n_num1   = NW'(sq_out.cm);
                n_den    = DENW'(sq_out.bm);
                n_s5.q1n = ((sq_out.cm != '0) && !sq_out.cn) != sq_out.bn;
            end
            K_DOUBLE: begin
                n_num1   = NW'(sq_out.bm);
                n_s5.q1n = ((sq_out.bm != '0) && !sq_out.bn) != sq_out.an;
            end
            K_TWO: begin
                n_num1   = sum1[NSW-1] ? NW'(-sum1) : NW'(sum1);
                n_num2   = sum2[NSW-1] ? NW'(-sum2) : NW'(sum2);
                n_s5.q1n = sum1[NSW-1] != sq_out.an;
                n_s5.q2n = sum2[NSW-1] != sq_out.an;
            end
            default: begin
                n_num1 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5    <= n_s5;
            r5_num1 <= n_num1;
            r5_num2 <= n_num2;
            r5_den  <= n_den;
        end
    end

    // ------------------------------------------------------------------
    // Two divider chains, QW cells each: (num << FRAC_BITS) / den
    // ------------------------------------------------------------------
    logic [QW-1:0]   d1_num [QW];
    logic [DENW-1:0] d1_rem [QW];
    logic [DENW-1:0] d1_den [QW];
    logic [QW-1:0]   d1_quo [QW];
    logic [QW-1:0]   d2_num [QW];
    logic [DENW-1:0] d2_rem [QW];
    logic [DENW-1:0] d2_den [QW];
    logic [QW-1:0]   d2_quo [QW];
    t_side           r_dv_side [QW];
    logic            r_dv_v    [QW];
    logic [QW-1:0]   dvd1, dvd2;

    assign dvd1 = {r5_num1, {FRAC_BITS{1'b0}}};
    assign dvd2 = {r5_num2, {FRAC_BITS{1'b0}}};

    generate
        for (gi = 0; gi < QW; gi++) begin : g_div
            if (gi == 0) begin : g_head
                qrs_div_cell #(.QW(QW), .DENW(DENW)) u_c1 (
                    .i_clk (i_clk), .i_en (en),
                    .i_num (dvd1), .i_rem ('0), .i_den (r5_den), .i_quo ('0),
                    .o_num (d1_num[gi]), .o_rem (d1_rem[gi]),
                    .o_den (d1_den[gi]), .o_quo (d1_quo[gi])
                );
                qrs_div_cell #(.QW(QW), .DENW(DENW)) u_c2 (
                    .i_clk (i_clk), .i_en (en),
                    .i_num (dvd2), .i_rem ('0), .i_den (r5_den), .i_quo ('0),
                    .o_num (d2_num[gi]), .o_rem (d2_rem[gi]),
                    .o_den (d2_den[gi]), .o_quo (d2_quo[gi])
                );
            end else begin : g_body
                qrs_div_cell #(.QW(QW), .DENW(DENW)) u_c1 (
                    .i_clk (i_clk), .i_en (en),
                    .i_num (d1_num[gi-1]), .i_rem (d1_rem[gi-1]),
                    .i_den (d1_den[gi-1]), .i_quo (d1_quo[gi-1]),
                    .o_num (d1_num[gi]), .o_rem (d1_rem[gi]),
                    .o_den (d1_den[gi]), .o_quo (d1_quo[gi])
                );
                qrs_div_cell #(.QW(QW), .DENW(DENW)) u_c2 (
                    .i_clk (i_clk), .i_en (en),
                    .i_num (d2_num[gi-1]), .i_rem (d2_rem[gi-1]),
                    .i_den (d2_den[gi-1]), .i_quo (d2_quo[gi-1]),
                    .o_num (d2_num[gi]), .o_rem (d2_rem[gi]),
                    .o_den (d2_den[gi]), .o_quo (d2_quo[gi])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_side[0] <= r_s5;
            for (int k = 1; k < QW; k++) begin
                r_dv_side[k] <= r_dv_side[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Fin 1: sign and saturation of both quotients
    // ------------------------------------------------------------------
    t_side          r_f1;
    logic           r_vf1;
    logic [W-1:0]   r_f1_r1, r_f1_r2;
    logic           r_f1_s1, r_f1_s2;
    t_side          dv_out;
    logic           sat1, sat2;
    logic [W-1:0]   root1, root2;

    always_comb begin
        dv_out = r_dv_side[QW-1];
        sat1   = dv_out.q1n ? (d1_quo[QW-1] > QLIM) : (d1_quo[QW-1] >= QLIM);
        sat2   = dv_out.q2n ? (d2_quo[QW-1] > QLIM) : (d2_quo[QW-1] >= QLIM);
        if (sat1) begin
            root1 = dv_out.q1n ? MINV : MAXV;
        end else begin
            root1 = dv_out.q1n ? -d1_quo[QW-1][W-1:0] : d1_quo[QW-1][W-1:0];
        end
        if (sat2) begin
            root2 = dv_out.q2n ? MINV : MAXV;
        end else begin
            root2 = dv_out.q2n ? -d2_quo[QW-1][W-1:0] : d2_quo[QW-1][W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1    <= dv_out;
            r_f1_r1 <= root1;
            r_f1_r2 <= root2;
            r_f1_s1 <= sat1;
            r_f1_s2 <= sat2;
        end
    end

    // ------------------------------------------------------------------
    // Fin 2: distance between the two roots
    // ------------------------------------------------------------------
    t_side          r_f2;
    logic           r_vf2;
    logic [W-1:0]   r_f2_r1, r_f2_r2;
    logic           r_f2_s1, r_f2_s2;
    logic [W:0]     r_f2_adiff;
    logic signed [W:0] rdiff;

    assign rdiff = $signed({r_f1_r1[W-1], r_f1_r1}) - $signed({r_f1_r2[W-1], r_f1_r2});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f2       <= r_f1;
            r_f2_r1    <= r_f1_r1;
            r_f2_r2    <= r_f1_r2;
            r_f2_s1    <= r_f1_s1;
            r_f2_s2    <= r_f1_s2;
            r_f2_adiff <= rdiff[W] ? -rdiff : rdiff;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    qrs_pkg::t_out_word n_out;
    qrs_pkg::t_out_word r_out;
    logic               r_out_valid;

    always_comb begin
        n_out                = '0;
        n_out.case_status    = r_f2.status;
        n_out.root_count     = r_f2.count;
        unique case (r_f2.kind)
            K_LINEAR: begin
                n_out.root_one       = r_f2_r1;
                n_out.root_saturated = r_f2_s1;
            end
            K_DOUBLE: begin
                n_out.root_one       = r_f2_r1;
                n_out.root_two       = r_f2_r1;
                n_out.root_saturated = r_f2_s1;
            end
            K_TWO: begin
                n_out.root_one = r_f2_r1;
                // roots no farther apart than the tolerance collapse to a double root
                if (r_f2_adiff <= (W+1)'(r_tol)) begin
                    n_out.case_status    = qrs_pkg::ST_DOUBLE;
                    n_out.root_count     = 2'd1;
                    n_out.root_two       = r_f2_r1;
                    n_out.root_saturated = r_f2_s1;
                end else begin
                    n_out.case_status    = qrs_pkg::ST_TWO;
                    n_out.root_count     = 2'd2;
                    n_out.root_two       = r_f2_r2;
                    n_out.root_saturated = r_f2_s1 || r_f2_s2;
                end
            end
            default: begin
                n_out.root_one = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    // ------------------------------------------------------------------
    // Valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_vf1       <= 1'b0;
            r_vf2       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < RW; k++) begin
                r_sq_v[k] <= 1'b0;
            end
            for (int k = 0; k < QW; k++) begin
                r_dv_v[k] <= 1'b0;
            end
        end else begin
            if (en) begin
                r_v1      <= i_in_valid;
                r_v2      <= r_v1;
                r_v3      <= r_v2;
                r_v4      <= r_v3;
                r_sq_v[0] <= r_v4;
                for (int k = 1; k < RW; k++) begin
                    r_sq_v[k] <= r_sq_v[k-1];
                end
                r_v5      <= r_sq_v[RW-1];
                r_dv_v[0] <= r_v5;
                for (int k = 1; k < QW; k++) begin
                    r_dv_v[k] <= r_dv_v[k-1];
                end
                r_vf1 <= r_dv_v[QW-1];
                r_vf2 <= r_vf1;
            end
            if (out_load) begin
                r_out_valid <= r_vf2;
            end
        end
    end

    assign v_last      = r_vf2;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_two_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.case_status == qrs_pkg::ST_TWO))
            |-> (o_out_word.root_count == 2'd2))
        else $error("two-root word without count of two");

    a_sat_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.root_saturated) |-> (o_out_word.root_count != 2'd0))
        else $error("saturation flagged with no root");

    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v1)
        else $error("accepted word missing from first stage");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && r_vf2))
        else $error("input stalled without a blocked output");

endmodule

// ----- sim/quadratic_root_solver_tb.sv -----
// Self-checking testbench for the quadratic root solver: random and corner coefficient words.
module quadratic_root_solver_tb;

    localparam int FB = qrs_pkg::FRAC_BITS_DEF;
    localparam int LAT = 2*qrs_pkg::COEF_W + FB + 11;
    localparam int WATCHDOG = 20000;
    localparam logic [qrs_pkg::ADDR_W-1:0] REG_TOL = '0;

    // Expected result words and comparison, one result per accepted word.
    class root_scoreboard;
        qrs_pkg::t_out_word pending[$];
        int mismatches;
        int tol;

        // Signed quotient (num << FB) / den, truncated, then saturated.
        function automatic logic signed [63:0] fx_div(logic signed [127:0] num,
                                                      logic signed [127:0] den,
                                                      inout bit sat);
            logic [127:0] nm, dm, q;
            bit neg;
            nm = num < 0 ? -num : num;
            dm = den < 0 ? -den : den;
            neg = (num < 0) != (den < 0) && nm != 0;
            q = (nm << FB) / dm;
            if (!neg && q > 128'h7fff_ffff) begin
                q = 128'h7fff_ffff; sat = 1;
            end
            if (neg && q > 128'h8000_0000) begin
                q = 128'h8000_0000; sat = 1;
            end
            return neg ? -$signed({1'b0, q[62:0]}) : $signed({1'b0, q[62:0]});
        endfunction

        function automatic logic [127:0] isqrt(logic [127:0] v);
            logic [127:0] r, b;
            r = 0;
            for (int i = 63; i >= 0; i--) begin
                b = r | (128'd1 << i);
                if (b * b <= v) r = b;
            end
            return r;
        endfunction

        function automatic void note_input(qrs_pkg::t_in_word w);
            qrs_pkg::t_out_word e;
            logic signed [127:0] a, b, c, d, s, dq;
            logic signed [63:0] r1, r2, diff;
            bit az, bz, cz, sat, s1, s2;
            a = w.coef_a; b = w.coef_b; c = w.coef_c;
            az = (a < 0 ? -a : a) <= tol;
            bz = (b < 0 ? -b : b) <= tol;
            cz = (c < 0 ? -c : c) <= tol;
            e = '0; sat = 0; r1 = 0; r2 = 0;
            if (az && bz) begin
                e.case_status = cz ? qrs_pkg::ST_ALL_REAL : qrs_pkg::ST_NONE;
            end else if (!az && bz && cz) begin
                e.case_status = qrs_pkg::ST_DOUBLE; e.root_count = 2'd1;
            end else if (az) begin
                e.case_status = qrs_pkg::ST_LINEAR; e.root_count = 2'd1;
                r1 = fx_div(-c, b, sat);
            end else begin
                d = b*b - 4*a*c;
                dq = d >>> FB;
                if (d < 0) begin
                    e.case_status = qrs_pkg::ST_NO_REAL;
                end else if (dq <= tol) begin
                    e.case_status = qrs_pkg::ST_DOUBLE; e.root_count = 2'd1;
                    r1 = fx_div(-b, 2*a, sat);
                    r2 = r1;
                end else begin
                    s = isqrt(d);
                    s1 = 0; s2 = 0;
                    r1 = fx_div(-b + s, 2*a, s1);
                    r2 = fx_div(-b - s, 2*a, s2);
                    diff = r1 - r2;
                    if (diff < 0) diff = -diff;
                    if (diff <= tol) begin
                        e.case_status = qrs_pkg::ST_DOUBLE; e.root_count = 2'd1;
                        r2 = r1; sat = s1;
                    end else begin
                        e.case_status = qrs_pkg::ST_TWO; e.root_count = 2'd2;
                        sat = s1 | s2;
                    end
                end
            end
            e.root_one = r1[31:0];
            e.root_two = r2[31:0];
            e.root_saturated = sat;
            pending.push_back(e);
        endfunction

        function automatic void check_result(qrs_pkg::t_out_word got);
            qrs_pkg::t_out_word e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp st=%0d n=%0d r1=%h r2=%h sat=%b",
                              " | got st=%0d n=%0d r1=%h r2=%h sat=%b"},
                             e.case_status, e.root_count, e.root_one, e.root_two,
                             e.root_saturated, got.case_status, got.root_count,
                             got.root_one, got.root_two, got.root_saturated);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_stall, o_out_valid, i_out_stall;
    qrs_pkg::t_in_word i_in_word;
    qrs_pkg::t_out_word o_out_word;
    logic psel, penable, pwrite, pready;
    logic [qrs_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    root_scoreboard sb;
    int idle_cycles;
    bit hold_long;
    int rx_max_gap;

    quadratic_root_solver uut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Register write: setup phase, then access phase.
    task automatic write_tolerance(int value);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= REG_TOL; pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.tol = value & 16'hffff;
    endtask

    function automatic logic [31:0] rand_coef(int tol);
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, tol);
            1: return -$urandom_range(0, tol);
            2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            3: return $signed($urandom_range(0, 32'h3ffff)) - 32'h20000;
            4: return $signed($urandom_range(0, 32'h7ffffff)) - 32'h4000000;
            default: return $urandom;
        endcase
    endfunction

    // Offers one word after a random gap; holds it until taken.
    // Valid stays high across a zero gap; the caller drops it when done.
    task automatic send_word(qrs_pkg::t_in_word w);
        int gap;
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1; i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(w);
    endtask

    task automatic send_random(int n);
        qrs_pkg::t_in_word w;
        for (int i = 0; i < n; i++) begin
            w.coef_a = rand_coef(sb.tol);
            w.coef_b = rand_coef(sb.tol);
            w.coef_c = rand_coef(sb.tol);
            // Often force a discriminant near zero for double and close roots.
            if ($urandom_range(0, 5) == 0) begin
                w.coef_a = $signed($urandom_range(1, 32'h3ffff)) - 32'h20000;
                if (w.coef_a == 0) w.coef_a = 1;
                w.coef_b = $signed($urandom_range(0, 32'h3ffff)) - 32'h20000;
                w.coef_c = (w.coef_b * w.coef_b) / (4 * w.coef_a)
                           + $signed($urandom_range(0, 4)) - 2;
            end
            send_word(w);
        end
    endtask

    task automatic drain;
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    // Receiver: random wait per word, plus one long hold-off on request.
    initial begin
        int wait_n;
        i_out_stall = 1;
        forever begin
            if (hold_long) begin
                i_out_stall <= 1;
                repeat (400) @(posedge i_clk);
                hold_long = 0;
            end
            wait_n = $urandom_range(0, rx_max_gap);
            if (wait_n != 0) begin
                i_out_stall <= 1;
                repeat (wait_n) @(posedge i_clk);
            end
            i_out_stall <= 0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Result words are taken at the clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_word);
    end

    // Watchdog on cycles with no accepted word and no taken result word.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        qrs_pkg::t_in_word w;
        logic [31:0] corner[6];
        sb = new();
        idle_cycles = 0; hold_long = 0; rx_max_gap = 7;
        i_rst_n = 0; i_in_valid = 0; i_in_word = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        write_tolerance(0);

        // Directed: every case plus extremes.
        corner = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000};
        send_word('{0, 0, 0});                                   // all reals
        send_word('{0, 0, 32'h0001_0000});                       // inconsistent
        send_word('{32'h0001_0000, 0, 0});                       // double root at zero
        send_word('{0, 32'h0002_0000, 32'h0004_0000});           // linear
        send_word('{0, 32'h0000_0001, 32'h7fff_ffff});           // linear, saturated
        send_word('{32'h0001_0000, 0, 32'h0001_0000});           // no real roots
        send_word('{32'h0001_0000, 32'h0002_0000, 32'h0001_0000}); // double root
        send_word('{32'h0001_0000, 32'hfffd_0000, 32'h0002_0000}); // two roots
        send_word('{32'h0000_0001, 32'h7fff_ffff, 32'h0});       // root saturates
        for (int i = 0; i < 16; i++) begin
            w.coef_a = corner[$urandom_range(0, 5)];
            w.coef_b = corner[$urandom_range(0, 5)];
            w.coef_c = corner[$urandom_range(0, 5)];
            send_word(w);
        end

        send_random(500);
        // Fill the pipeline against a stalled output.
        hold_long = 1;
        send_random(150);
        drain();
        write_tolerance(65535);
        send_random(350);
        drain();
        write_tolerance(32'h1234_0040);
        rx_max_gap = 1;
        send_random(350);
        drain();
        write_tolerance(3);
        rx_max_gap = 7;
        send_random(300);
        drain();

        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
